>>> rtl/core/ltt_pkg.sv
package ltt_pkg;

  // table geometry
  localparam int unsigned INDEX_BITS = 12;
  localparam int unsigned SLOT_COUNT = 1 << INDEX_BITS;
  localparam int unsigned WORD_BITS  = 64;

  // empty slot: depth -1, score 0, bound 0, move -1, check equal to data
  localparam logic [WORD_BITS-1:0] EMPTY_WORD = 64'hFF00_FFFF_0000_0000;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [WORD_BITS-1:0]  word_t;

  typedef enum logic [1:0] {
    FN_PROBE = 2'd0,
    FN_STORE = 2'd1,
    FN_CLEAR = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_WALK,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // request word held for the slot update
  typedef struct packed {
    logic [1:0]         func;
    logic [63:0]        key;
    logic signed [15:0] depth;
    logic signed [31:0] score;
    logic [1:0]         bound;
    logic signed [7:0]  best_move;
  } req_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic       req_fire;
    logic [1:0] req_func;
    logic [1:0] exec_func;
    logic       rsp_stall;
  } stat_t;

  // controls from sequencer to datapath
  typedef struct packed {
    logic req_ready;
    logic exec;
    logic walk;
    idx_t walk_idx;
  } ctrl_t;

endpackage

>>> rtl/core/ltt_if.sv
interface ltt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [63:0]        key;
  logic signed [15:0] depth;
  logic signed [31:0] score;
  logic [1:0]         bound;
  logic signed [7:0]  best_move;

  modport source (output valid, func, key, depth, score, bound, best_move, input ready);
  modport sink   (input valid, func, key, depth, score, bound, best_move, output ready);
endinterface

interface ltt_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] out_score;
  logic signed [15:0] out_depth;
  logic [7:0]         out_bound;
  logic signed [7:0]  out_move;
  logic [31:0]        hit_count;

  modport source (output valid, hit, out_score, out_depth, out_bound, out_move, hit_count,
                  input ready);
  modport sink   (input valid, hit, out_score, out_depth, out_bound, out_move, hit_count,
                  output ready);
endinterface

>>> rtl/core/ltt_ram.sv
module ltt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ltt_ctrl.sv
module ltt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ltt_pkg::stat_t stat_i,
  output ltt_pkg::ctrl_t ctrl_o
);
  import ltt_pkg::*;

  state_e state_q, state_d;
  idx_t   walk_q, walk_d;
  logic   walk_last;

  assign walk_last = (walk_q == {INDEX_BITS{1'b1}});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_WALK: begin
        if (walk_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (stat_i.req_fire) begin
          case (stat_i.req_func)
            FN_PROBE, FN_STORE: state_d = ST_EXEC;
            FN_CLEAR:           state_d = ST_WALK;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: begin
        if (!(stat_i.exec_func == FN_PROBE && stat_i.rsp_stall)) state_d = ST_IDLE;
      end
      default: state_d = ST_WALK;
    endcase
  end

  // advance the sweep index; it wraps back to zero at the end of a sweep
  assign walk_d = (state_q == ST_WALK) ? walk_q + idx_t'(1) : walk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WALK;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
    end
  end

  // outputs
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.walk_idx  = walk_q;
    unique case (state_q)
      ST_WALK: ctrl_o.walk      = 1'b1;
      ST_IDLE: ctrl_o.req_ready = 1'b1;
      ST_EXEC: ctrl_o.exec      = 1'b1;
      default: ctrl_o.walk      = 1'b1;
    endcase
  end

endmodule

>>> rtl/core/lockless_transposition_table.sv
// channel | dir | word
// req_i   | in  | func, key, depth, score, bound, best_move
// rsp_o   | out | hit, out_score, out_depth, out_bound, out_move, hit_count
//
// A probe or store is accepted with its slot read, then compares and writes
// back or loads the result register. The slot read is registered.
// After reset and after each clear, a sweep writes the empty word into all
// 4096 slots, one per cycle; no word is accepted during the sweep.
// A probe waits in its compare step while the result register is still full.
module lockless_transposition_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  ltt_req_if.sink   req_i,
  ltt_rsp_if.source rsp_o
);
  import ltt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  req_t  req_q;
  word_t rd_data, rd_check;
  logic  req_fire, rsp_stall;
  logic  we;
  idx_t  waddr;
  word_t wdata, wcheck;
  word_t new_data;
  logic  key_match, slot_valid, keep_old, probe_hit, probe_load;

  logic        rsp_valid_q;
  logic        hit_q;
  logic [31:0] score_q;
  logic [15:0] depth_q;
  logic [7:0]  bound_q;
  logic [7:0]  move_q;
  logic [31:0] count_q, count_d;
  logic [31:0] count_out_q;

  assign req_fire  = req_i.valid && ctrl.req_ready;
  assign rsp_stall = rsp_valid_q && !rsp_o.ready;

  assign stat.req_fire  = req_fire;
  assign stat.req_func  = req_i.func;
  assign stat.exec_func = req_q.func;
  assign stat.rsp_stall = rsp_stall;

  ltt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // hold the accepted word
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q.func      <= req_i.func;
      req_q.key       <= req_i.key;
      req_q.depth     <= req_i.depth;
      req_q.score     <= req_i.score;
      req_q.bound     <= req_i.bound;
      req_q.best_move <= req_i.best_move;
    end
  end

  // slot compare
  assign key_match  = ((rd_check ^ rd_data) == req_q.key);
  assign slot_valid = !rd_data[47];
  assign probe_hit  = key_match && slot_valid;
  assign keep_old   = slot_valid && !key_match &&
                      ($signed(rd_data[47:32]) > req_q.depth);
  assign new_data   = {req_q.best_move, 6'b0, req_q.bound, req_q.depth, req_q.score};

  // write back: sweep fills the empty word, store replaces unless kept
  always_comb begin
    if (ctrl.walk) begin
      we     = 1'b1;
      waddr  = ctrl.walk_idx;
      wdata  = EMPTY_WORD;
      wcheck = EMPTY_WORD;
    end else begin
      we     = ctrl.exec && (req_q.func == FN_STORE) && !keep_old;
      waddr  = req_q.key[INDEX_BITS-1:0];
      wdata  = new_data;
      wcheck = req_q.key ^ new_data;
    end
  end

  ltt_ram #(.WIDTH(WORD_BITS), .DEPTH(SLOT_COUNT)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (req_fire),
    .raddr_i (req_i.key[INDEX_BITS-1:0]),
    .rdata_o (rd_data)
  );

  ltt_ram #(.WIDTH(WORD_BITS), .DEPTH(SLOT_COUNT)) u_check_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wcheck),
    .re_i    (req_fire),
    .raddr_i (req_i.key[INDEX_BITS-1:0]),
    .rdata_o (rd_check)
  );

  assign probe_load = ctrl.exec && (req_q.func == FN_PROBE) && !rsp_stall;

  // hit counter: zero on clear, bump on a hit
  always_comb begin
    count_d = count_q;
    if (req_fire && req_i.func == FN_CLEAR) begin
      count_d = '0;
    end else if (probe_load && probe_hit) begin
      count_d = count_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (probe_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (probe_load) begin
      hit_q   <= probe_hit;
      score_q <= probe_hit ? rd_data[31:0]  : '0;
      depth_q <= probe_hit ? rd_data[47:32] : '0;
      bound_q <= probe_hit ? rd_data[55:48] : '0;
      move_q  <= probe_hit ? rd_data[63:56] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (probe_load) begin
      count_out_q <= count_d;
    end
  end

  assign req_i.ready     = ctrl.req_ready;
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.hit       = hit_q;
  assign rsp_o.out_score = score_q;
  assign rsp_o.out_depth = depth_q;
  assign rsp_o.out_bound = bound_q;
  assign rsp_o.out_move  = move_q;
  assign rsp_o.hit_count = count_out_q;

endmodule

>>> rtl/core/ltt_checker.sv
module ltt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid,
  input logic               req_ready,
  input logic [1:0]         req_func,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               rsp_hit,
  input logic [31:0]        rsp_score,
  input logic [15:0]        rsp_depth,
  input logic [7:0]         rsp_bound,
  input logic [7:0]         rsp_move,
  input logic [31:0]        rsp_count
);
  import ltt_pkg::*;

  // a waiting result holds its hit, score and count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_score) &&
      $stable(rsp_count))
    else $error("stalled result changed");

  // a miss carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_hit |-> rsp_score == 32'd0 && rsp_depth == 16'd0 &&
      rsp_bound == 8'd0 && rsp_move == 8'd0)
    else $error("miss with nonzero fields");

  // a hit never reports an empty (negative) depth or a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_hit |-> !rsp_depth[15] && rsp_count != 32'd0)
    else $error("hit with negative depth or zero count");

  // a clear starts the sweep at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && req_func == FN_CLEAR |=> !req_ready)
    else $error("word accepted during sweep");

endmodule

bind lockless_transposition_table ltt_checker u_ltt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req_i.valid),
  .req_ready (req_i.ready),
  .req_func  (req_i.func),
  .rsp_valid (rsp_o.valid),
  .rsp_ready (rsp_o.ready),
  .rsp_hit   (rsp_o.hit),
  .rsp_score (rsp_o.out_score),
  .rsp_depth (rsp_o.out_depth),
  .rsp_bound (rsp_o.out_bound),
  .rsp_move  (rsp_o.out_move),
  .rsp_count (rsp_o.hit_count)
);

>>> bench/lockless_transposition_table_test.sv
`timescale 1ns / 1ps

module lockless_transposition_table_test;
  import ltt_pkg::*;

  // func code that the table ignores
  localparam logic [1:0] FN_UNUSED = 2'd3;
  // longest run of cycles without any word moving, which must also cover a clear sweep
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned KEY_POOL = 16;
  localparam int unsigned PHASE_WORDS = 130;

  // one probe result as seen on the response channel
  typedef struct packed {
    logic               hit;
    logic signed [31:0] score;
    logic signed [15:0] depth;
    logic [7:0]         bound;
    logic signed [7:0]  move;
    logic [31:0]        count;
  } lookup_t;

  typedef struct {
    req_t    word;
    bit      typed;
    lookup_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  ltt_req_if req_bus ();
  ltt_rsp_if rsp_bus ();

  lockless_transposition_table dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table
  word_t       slot_data [SLOT_COUNT];
  word_t       slot_check[SLOT_COUNT];
  logic [31:0] probe_hits;

  lookup_t     pending_lookups[$];
  row_t        directed_rows[$];
  logic [63:0] key_pool[KEY_POOL];
  int unsigned fail_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_burst = 0;
  int unsigned quiet_cycles = 0;

  function automatic void wipe_table();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_data[i]  = EMPTY_WORD;
      slot_check[i] = EMPTY_WORD;
    end
    probe_hits = '0;
  endfunction

  // advance the shadow table by one word; return 1 when a probe result is due
  function automatic bit apply_to_table(input req_t w, output lookup_t res);
    word_t              d;
    word_t              c;
    word_t              nd;
    idx_t               slot;
    logic signed [15:0] old_depth;
    res       = '0;
    slot      = w.key[INDEX_BITS-1:0];
    d         = slot_data[slot];
    c         = slot_check[slot];
    old_depth = d[47:32];
    case (w.func)
      FN_PROBE: begin
        if ((c ^ d) == w.key && old_depth >= 0) begin
          probe_hits = probe_hits + 32'd1;
          res.hit    = 1'b1;
          res.score  = d[31:0];
          res.depth  = d[47:32];
          res.bound  = d[55:48];
          res.move   = d[63:56];
        end
        res.count = probe_hits;
        return 1'b1;
      end
      FN_STORE: begin
        // keep a deeper valid entry of another position
        if (!(old_depth >= 0 && (c ^ d) != w.key && old_depth > $signed(w.depth))) begin
          nd = {w.best_move, 6'b0, w.bound, w.depth, w.score};
          slot_data[slot]  = nd;
          slot_check[slot] = w.key ^ nd;
        end
      end
      FN_CLEAR: wipe_table();
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic req_t make_word(logic [1:0] func, logic [63:0] key, int depth, int score,
                                     int bound, int move);
    req_t w;
    w.func      = func;
    w.key       = key;
    w.depth     = depth[15:0];
    w.score     = score;
    w.bound     = bound[1:0];
    w.best_move = move[7:0];
    return w;
  endfunction

  function automatic lookup_t make_lookup(bit hit, int score, int depth, int bound, int move,
                                          int unsigned count);
    lookup_t r;
    r.hit   = hit;
    r.score = score;
    r.depth = depth[15:0];
    r.bound = bound[7:0];
    r.move  = move[7:0];
    r.count = count;
    return r;
  endfunction

  task automatic add_row(req_t w, bit typed, lookup_t want);
    row_t r;
    r.word  = w;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  // mostly keys that collide on a few hot slots, now and then a fresh one
  function automatic req_t random_word();
    req_t        w;
    int unsigned r;
    r = $urandom_range(199);
    if (r < 95) w.func = FN_PROBE;
    else if (r < 190) w.func = FN_STORE;
    else if (r < 197) w.func = FN_UNUSED;
    else w.func = FN_CLEAR;
    if ($urandom_range(9) == 0) w.key = {$urandom, $urandom};
    else w.key = key_pool[$urandom_range(KEY_POOL - 1)];
    case ($urandom_range(9))
      0: w.depth = 16'($urandom);
      1: w.depth = -$signed(16'($urandom_range(1, 4)));
      default: w.depth = 16'($urandom_range(0, 24));
    endcase
    w.score     = $urandom;
    w.bound     = 2'($urandom_range(2));
    w.best_move = 8'($urandom);
    return w;
  endfunction

  // offer one word, hold it until accepted, then log what it should return
  task automatic push_word(req_t w, bit typed, lookup_t want);
    lookup_t res;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.func      <= w.func;
    req_bus.key       <= w.key;
    req_bus.depth     <= w.depth;
    req_bus.score     <= w.score;
    req_bus.bound     <= w.bound;
    req_bus.best_move <= w.best_move;
    do @(posedge clk); while (!req_bus.ready);
    if (apply_to_table(w, res)) pending_lookups.push_back(typed ? want : res);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_lookups.size() != 0);
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // response side: random stalls, plus a long hold-off on request
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_burst != 0) begin
        stall_burst   = stall_burst - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result, expected none, got hit %b count %h", $time,
                 rsp_bus.hit, rsp_bus.hit_count);
        fail_count++;
      end else begin
        want = pending_lookups.pop_front();
        check_field("hit", 64'(want.hit), 64'(rsp_bus.hit));
        check_field("out_score", 64'(want.score), 64'(rsp_bus.out_score));
        check_field("out_depth", 64'(want.depth), 64'(rsp_bus.out_depth));
        check_field("out_bound", 64'(want.bound), 64'(rsp_bus.out_bound));
        check_field("out_move", 64'(want.move), 64'(rsp_bus.out_move));
        check_field("hit_count", 64'(want.count), 64'(rsp_bus.hit_count));
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    lookup_t none;
    none = '0;
    rst_n = 1'b0;
    req_bus.valid     <= 1'b0;
    req_bus.func      <= FN_PROBE;
    req_bus.key       <= '0;
    req_bus.depth     <= '0;
    req_bus.score     <= '0;
    req_bus.bound     <= '0;
    req_bus.best_move <= '0;
    wipe_table();
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i]       = {$urandom, $urandom};
      key_pool[i][11:0] = 12'((i % 4) * 12'h555);
    end

    // empty table, depth-preferred replacement, negative depth, ignored func, clear
    add_row(make_word(FN_PROBE, 64'h0, 0, 0, 0, 0), 1, make_lookup(0, 0, 0, 0, 0, 0));
    add_row(make_word(FN_PROBE, '1, 0, 0, 0, 0), 1, make_lookup(0, 0, 0, 0, 0, 0));
    add_row(make_word(FN_STORE, 64'h0, 32767, 32'h7fffffff, 2, 127), 0, none);
    add_row(make_word(FN_PROBE, 64'h0, 0, 0, 0, 0), 1,
            make_lookup(1, 32'h7fffffff, 32767, 2, 127, 1));
    add_row(make_word(FN_STORE, 64'h1000, 0, 5, 0, 3), 0, none);
    add_row(make_word(FN_PROBE, 64'h1000, 0, 0, 0, 0), 1, make_lookup(0, 0, 0, 0, 0, 1));
    add_row(make_word(FN_PROBE, 64'h0, 0, 0, 0, 0), 1,
            make_lookup(1, 32'h7fffffff, 32767, 2, 127, 2));
    add_row(make_word(FN_STORE, 64'h1000, 32767, 32'h80000000, 1, -128), 0, none);
    add_row(make_word(FN_PROBE, 64'h1000, 0, 0, 0, 0), 1,
            make_lookup(1, 32'h80000000, 32767, 1, -128, 3));
    add_row(make_word(FN_PROBE, 64'h0, 0, 0, 0, 0), 1, make_lookup(0, 0, 0, 0, 0, 3));
    add_row(make_word(FN_STORE, 64'h1000, 3, -7, 0, -1), 0, none);
    add_row(make_word(FN_PROBE, 64'h1000, 0, 0, 0, 0), 0, none);
    add_row(make_word(FN_STORE, '1, -32768, -1, 0, -1), 0, none);
    add_row(make_word(FN_PROBE, '1, 0, 0, 0, 0), 1, make_lookup(0, 0, 0, 0, 0, 4));
    add_row(make_word(FN_STORE, '1, 5, 100, 2, 63), 0, none);
    add_row(make_word(FN_PROBE, '1, 0, 0, 0, 0), 0, none);
    add_row(make_word(FN_UNUSED, 64'h1000, 0, 0, 0, 0), 0, none);
    add_row(make_word(FN_PROBE, 64'h1000, 0, 0, 0, 0), 0, none);
    add_row(make_word(FN_CLEAR, 64'h0, 0, 0, 0, 0), 0, none);
    add_row(make_word(FN_PROBE, 64'h1000, 0, 0, 0, 0), 1, make_lookup(0, 0, 0, 0, 0, 0));
    add_row(make_word(FN_PROBE, 64'h0, 0, 0, 0, 0), 1, make_lookup(0, 0, 0, 0, 0, 0));
    add_row(make_word(FN_STORE, 64'h0, 0, 0, 0, 0), 0, none);
    add_row(make_word(FN_PROBE, 64'h0, 0, 0, 0, 0), 0, none);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      push_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

    // hold off the response side while probes keep coming, so the input backs up
    stall_burst = 400;
    for (int i = 0; i < 40; i++)
      push_word(make_word(FN_PROBE, key_pool[i % KEY_POOL], 0, 0, 0, 0), 0, none);
    wait_drained();

    // random traffic under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 86; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 86; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) push_word(random_word(), 0, none);
    end

    gap_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_lookups.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
